@@ rtl/core/lkvc_pkg.sv @@
// lkvc_pkg: shared constants, field widths, controller state and command types
// for the lru key/value cache; no dependencies
package lkvc_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int CAP_RESET       = 16;

    // request operation codes
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT,
        ST_FINISH
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic search;
        logic commit;
        logic finish;
    } dp_cmd_t;

endpackage

@@ rtl/core/lkvc_if.sv @@
// lkvc_if: valid/ready channel interfaces for requests and responses
// depends on lkvc_pkg
interface lkvc_req_if
    import lkvc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, found, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

@@ rtl/core/lkvc_ram.sv @@
// lkvc_ram: generic single write port, single read port ram with registered read
// no dependencies
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lkvc_ctrl.sv @@
// lkvc_ctrl: request sequencer and response valid register
// depends on lkvc_pkg
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the response register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.finish | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("response raised outside finish state");
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

@@ rtl/core/lkvc_dp.sv @@
// lkvc_dp: entry keys, valid bits and age ranks, parallel search, recency update,
// value ram and response payload registers; depends on lkvc_pkg and lkvc_ram
module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             req_mode,
    input  logic [KEY_W-1:0] req_key,
    input  logic [VAL_W-1:0] req_value,
    output logic             found,
    output logic [VAL_W-1:0] read_value,
    output logic             evicted,
    output logic [KEY_W-1:0] evicted_key
);

    localparam int IW       = $clog2(ENTRIES);
    localparam int OW       = $clog2(ENTRIES + 1);
    localparam int CMP_W    = (OW > CAP_W) ? OW : CAP_W;
    localparam int CAP_INIT = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

    // entry state
    logic [ENTRIES-1:0] valid_reg,  valid_next;
    logic [IW-1:0]      age_reg     [ENTRIES];
    logic [IW-1:0]      age_next    [ENTRIES];
    logic [KEY_W-1:0]   key_reg     [ENTRIES];
    logic [KEY_W-1:0]   key_next    [ENTRIES];
    logic [OW-1:0]      occ_reg,    occ_next;
    logic [CAP_W-1:0]   cap_reg,    cap_next;

    // captured request
    logic               req_mode_reg;
    logic [KEY_W-1:0]   req_key_reg;
    logic [VAL_W-1:0]   req_value_reg;

    // search results
    logic               hit_reg,       hit_next;
    logic [IW-1:0]      hit_idx_reg,   hit_idx_next;
    logic [IW-1:0]      hit_age_reg;
    logic               vic_found_reg, vic_found_next;
    logic [IW-1:0]      vic_idx_reg,   vic_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg,  free_idx_next;

    // result staging and response payload
    logic               res_found_reg,   res_found_next;
    logic               res_get_hit_reg, res_get_hit_next;
    logic               res_ev_reg,      res_ev_next;
    logic [KEY_W-1:0]   res_evk_reg,     res_evk_next;
    logic               found_reg;
    logic [VAL_W-1:0]   read_value_reg;
    logic               evicted_reg;
    logic [KEY_W-1:0]   evicted_key_reg;

    // value store
    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr;
    logic [VAL_W-1:0]   ram_rdata;

    logic [OW-1:0]      occ_m1;
    logic               at_cap, evict, ins_ok;
    logic [IW-1:0]      slot;
    logic [ENTRIES-1:0] young;

    // parallel key compare and priority encoders
    always_comb
    begin
        hit_next        = 1'b0;
        hit_idx_next    = '0;
        vic_found_next  = 1'b0;
        vic_idx_next    = '0;
        free_found_next = 1'b0;
        free_idx_next   = '0;
        occ_m1          = occ_reg - OW'(1);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == req_key_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = IW'(i);
            end
            if (valid_reg[i] && OW'(age_reg[i]) == occ_m1)
            begin
                vic_found_next = 1'b1;
                vic_idx_next   = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_found_next = 1'b1;
                free_idx_next   = IW'(i);
            end
        end
    end

    assign at_cap = (CMP_W'(occ_reg) >= CMP_W'(cap_reg)) && (occ_reg != '0);
    assign evict  = at_cap && vic_found_reg;
    assign ins_ok = evict || free_found_reg;
    assign slot   = evict ? vic_idx_reg : free_idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        key_next   = key_reg;
        occ_next   = occ_reg;
        cap_next   = cap_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = hit_idx_reg;

        res_found_next   = hit_reg;
        res_get_hit_next = hit_reg && (req_mode_reg == MODE_GET);
        res_ev_next      = !hit_reg && (req_mode_reg == MODE_PUT) && evict;
        res_evk_next     = res_ev_next ? key_reg[vic_idx_reg] : '0;

        if (cfg_we)
        begin
            // capacity write clamps and empties the store
            if (cfg_wdata == '0)
            begin
                cap_next = CAP_W'(1);
            end
            else if (int'(cfg_wdata) > ENTRIES)
            begin
                cap_next = CAP_W'(ENTRIES);
            end
            else
            begin
                cap_next = cfg_wdata;
            end
            valid_next = '0;
            occ_next   = '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_next[i] = '0;
            end
        end
        else if (cmd.commit)
        begin
            if (hit_reg)
            begin
                // move hit entry to front, younger entries age by one
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && age_reg[i] < hit_age_reg)
                    begin
                        age_next[i] = age_reg[i] + IW'(1);
                    end
                end
                age_next[hit_idx_reg] = '0;
                if (req_mode_reg == MODE_PUT)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            else if (req_mode_reg == MODE_PUT && ins_ok)
            begin
                // insert at front, reusing the victim slot when full
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && IW'(i) != slot)
                    begin
                        age_next[i] = age_reg[i] + IW'(1);
                    end
                end
                valid_next[slot] = 1'b1;
                key_next[slot]   = req_key_reg;
                age_next[slot]   = '0;
                ram_we           = 1'b1;
                ram_waddr        = slot;
                if (!evict)
                begin
                    occ_next = occ_reg + OW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_W'(CAP_INIT);
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (cmd.capture)
        begin
            req_mode_reg  <= req_mode;
            req_key_reg   <= req_key;
            req_value_reg <= req_value;
        end
        if (cmd.search)
        begin
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_age_reg    <= age_reg[hit_idx_next];
            vic_found_reg  <= vic_found_next;
            vic_idx_reg    <= vic_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
        end
        if (cmd.commit)
        begin
            res_found_reg   <= res_found_next;
            res_get_hit_reg <= res_get_hit_next;
            res_ev_reg      <= res_ev_next;
            res_evk_reg     <= res_evk_next;
        end
        if (cmd.finish)
        begin
            found_reg       <= res_found_reg;
            read_value_reg  <= res_get_hit_reg ? ram_rdata : '1;
            evicted_reg     <= res_ev_reg;
            evicted_key_reg <= res_evk_reg;
        end
    end

    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_value_reg),
        .re    (ram_re),
        .raddr (hit_idx_reg),
        .rdata (ram_rdata)
    );

    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            young[i] = valid_reg[i] && (age_reg[i] == '0);
        end
    end

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy disagrees with valid bits");
    a_occ_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(cap_reg))
        else $error("occupancy above capacity");
    a_one_most_recent: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(young))
        else $error("several entries hold the most recent rank");
`endif

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// lru_key_value_cache: top level of the fully associative lru key/value cache
// depends on lkvc_pkg, lkvc_if, lkvc_ctrl, lkvc_dp (and lkvc_ram below it)
// sequencing: after the capture edge a request steps through search, commit and
//   finish, where response valid is registered; one item at a time through the sequencer
// flow: a new request is taken only back in idle, once the last response is loaded
// reset: asynchronous active low; store empty, capacity 16 (clamped to ENTRIES)
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic             clk,
    input  logic             rst_n,
    lkvc_req_if.sink         req,
    lkvc_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    // command bundle from the sequencer into the datapath
    dp_cmd_t cmd;

    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    // sequencer: takes a request transfer in idle, steps the datapath through
    // search and commit, then loads the response register when it is free
    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // datapath: keys and ranks in flops for the parallel compare, values in ram;
    // a capacity write empties the store
    lkvc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_mode    (req.mode),
        .req_key     (req.key),
        .req_value   (req.value),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    // response payload straight from the datapath output registers
    assign rsp.found       = found;
    assign rsp.read_value  = read_value;
    assign rsp.evicted     = evicted;
    assign rsp.evicted_key = evicted_key;

endmodule
